>>> rtl/core/mf3_pkg.sv
// mf3_pkg: shared types and constants of the 3x3 median filter.
// Used by median_filter_3x3, mf3_checker and tb_median_filter_3x3; no dependencies.
package mf3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int PIX_BITS    = 8;
  localparam int TAPS        = 9;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WID_BITS    = 11;
  localparam int ROW_BITS    = 12;
  localparam int IN_ROW_BITS = ROW_BITS + 1;
  localparam int CFG_BITS    = 12;
  localparam int IDX_BITS    = 1;

  localparam logic [WID_BITS-1:0] WIDTH_RESET  = WID_BITS'(640);
  localparam logic [ROW_BITS-1:0] HEIGHT_RESET = ROW_BITS'(480);

  localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [TAPS-1:0][PIX_BITS-1:0] pix9_t;

  typedef struct packed {
    logic kind;
    pix_t pixel_in;
  } in_word_t;

  typedef struct packed {
    pix_t pixel_out;
    logic last_of_frame;
  } out_word_t;

endpackage

>>> rtl/core/median_filter_3x3.sv
// median_filter_3x3: streaming 3x3 median filter with a combined line-store RAM.
// Depends on mf3_pkg for word types and size constants.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------
//  in      | in  | in_valid/in_stall  | in_word  (kind, pixel_in)
//  out     | out | out_valid/out_stall| out_word (pixel_out, last_of_frame)
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// One word per clock unless in_stall; a result passes the m, s1, s2 and out stages.
// Both line stores share one 1024x16 RAM, one read and one write per cycle,
// with forwarding when consecutive words hit the same column.
// Synchronous reset clears counters and pipeline valids; the RAM is not cleared.
// in_stall rises only while the output register is full and out_stall is high.
module median_filter_3x3 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mf3_pkg::in_word_t                  in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mf3_pkg::out_word_t                 out_word,
  input  logic                               cfg_we,
  input  logic [mf3_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [mf3_pkg::CFG_BITS-1:0]       cfg_data
);

  // compare-and-swap, returns {max, min}
  function automatic logic [2*mf3_pkg::PIX_BITS-1:0] cas(mf3_pkg::pix_t a, mf3_pkg::pix_t b);
    cas = (a > b) ? {a, b} : {b, a};
  endfunction

  // first three levels: sort each row of three
  function automatic mf3_pkg::pix9_t med_front(mf3_pkg::pix9_t a);
    mf3_pkg::pix9_t v;
    v = a;
    {v[2], v[1]} = cas(v[1], v[2]);
    {v[5], v[4]} = cas(v[4], v[5]);
    {v[8], v[7]} = cas(v[7], v[8]);
    {v[1], v[0]} = cas(v[0], v[1]);
    {v[4], v[3]} = cas(v[3], v[4]);
    {v[7], v[6]} = cas(v[6], v[7]);
    {v[2], v[1]} = cas(v[1], v[2]);
    {v[5], v[4]} = cas(v[4], v[5]);
    {v[8], v[7]} = cas(v[7], v[8]);
    med_front = v;
  endfunction

  function automatic mf3_pkg::pix_t med_back(mf3_pkg::pix9_t a);
    mf3_pkg::pix9_t v;
    v = a;
    {v[3], v[0]} = cas(v[0], v[3]);
    {v[8], v[5]} = cas(v[5], v[8]);
    {v[7], v[4]} = cas(v[4], v[7]);
    {v[6], v[3]} = cas(v[3], v[6]);
    {v[4], v[1]} = cas(v[1], v[4]);
    {v[5], v[2]} = cas(v[2], v[5]);
    {v[7], v[4]} = cas(v[4], v[7]);
    {v[2], v[4]} = cas(v[4], v[2]);
    {v[4], v[6]} = cas(v[6], v[4]);
    {v[2], v[4]} = cas(v[4], v[2]);
    med_back = v[4];
  endfunction

  // configuration
  logic [mf3_pkg::WID_BITS-1:0] cfg_width_r;
  logic [mf3_pkg::ROW_BITS-1:0] cfg_height_r;
  logic [mf3_pkg::WID_BITS-1:0] w_eff;
  logic [mf3_pkg::ROW_BITS-1:0] h_eff;

  // position counters
  logic [mf3_pkg::COL_BITS-1:0]    in_col_r,  in_col_nxt;
  logic [mf3_pkg::IN_ROW_BITS-1:0] in_row_r,  in_row_nxt;
  logic [mf3_pkg::COL_BITS-1:0]    out_col_r, out_col_nxt;
  logic [mf3_pkg::ROW_BITS-1:0]    out_row_r, out_row_nxt;

  // line-store RAM: [15:8] upper row, [7:0] middle row
  logic [2*mf3_pkg::PIX_BITS-1:0] lmem [mf3_pkg::MAX_WIDTH];
  logic [2*mf3_pkg::PIX_BITS-1:0] mem_rd_r;

  // memory stage
  logic                           m_v_r, m_v_nxt;
  logic [mf3_pkg::COL_BITS-1:0]   m_col_r;
  mf3_pkg::pix_t                  m_pix_r;
  logic                           m_res_r, m_int_r, m_last_r;
  logic                           m_fwd_r;
  logic [2*mf3_pkg::PIX_BITS-1:0] m_fwd_data_r;
  logic [2*mf3_pkg::PIX_BITS-1:0] m_data;
  mf3_pkg::pix_t                  m_top, m_mid;

  mf3_pkg::pix9_t win_r;

  logic          s1_v_r, s1_v_nxt, s1_int_r, s1_last_r;
  logic          s2_v_r, s2_v_nxt, s2_int_r, s2_last_r;
  mf3_pkg::pix9_t s2_vals_r;
  mf3_pkg::pix_t  s2_center_r;

  logic               out_v_r, out_v_nxt;
  mf3_pkg::out_word_t out_word_r;

  logic out_free, s2_free, s1_free, m_free;
  logic s2_move, s1_move, m_move;
  logic acc, frame_done, drop, acc_pix, has_res, res_int, res_last;
  mf3_pkg::pix_t acc_p;
  logic [mf3_pkg::WID_BITS-1:0]    in_col_inc, out_col_inc;
  logic [mf3_pkg::IN_ROW_BITS-1:0] out_row_inc;

  assign w_eff = (cfg_width_r == '0) ? mf3_pkg::WID_BITS'(1) :
                 (cfg_width_r > mf3_pkg::WID_BITS'(mf3_pkg::MAX_WIDTH)) ?
                 mf3_pkg::WID_BITS'(mf3_pkg::MAX_WIDTH) : cfg_width_r;
  assign h_eff = (cfg_height_r == '0) ? mf3_pkg::ROW_BITS'(1) : cfg_height_r;

  // pipeline flow, bubbles collapse
  assign out_free = !out_v_r || !out_stall;
  assign s2_move  = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign m_move   = m_v_r && s1_free;
  assign m_free   = !m_v_r || s1_free;
  assign in_stall = !m_free;

  assign acc        = in_valid && !in_stall;
  assign frame_done = in_row_r >= {1'b0, h_eff};
  assign drop       = !frame_done && in_word.kind;
  assign acc_pix    = acc && !drop;
  assign acc_p      = frame_done ? '0 : in_word.pixel_in;

  assign in_col_inc  = {1'b0, in_col_r} + mf3_pkg::WID_BITS'(1);
  assign out_col_inc = {1'b0, out_col_r} + mf3_pkg::WID_BITS'(1);
  assign out_row_inc = {1'b0, out_row_r} + mf3_pkg::IN_ROW_BITS'(1);

  assign has_res = (in_row_r >= mf3_pkg::IN_ROW_BITS'(2)) ||
                   ((in_row_r == mf3_pkg::IN_ROW_BITS'(1)) && (in_col_r != '0));
  assign res_int = (out_row_r != '0) && (out_row_inc < {1'b0, h_eff}) &&
                   (out_col_r != '0) && (out_col_inc < w_eff);
  assign res_last = (out_row_inc >= {1'b0, h_eff}) && (out_col_inc >= w_eff);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (acc_pix) begin
      if (in_col_inc >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + mf3_pkg::IN_ROW_BITS'(1);
      end else begin
        in_col_nxt = in_col_inc[mf3_pkg::COL_BITS-1:0];
      end
      if (has_res) begin
        if (res_last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_inc >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_inc[mf3_pkg::ROW_BITS-1:0];
        end else begin
          out_col_nxt = out_col_inc[mf3_pkg::COL_BITS-1:0];
        end
      end
    end
  end

  assign m_data = m_fwd_r ? m_fwd_data_r : mem_rd_r;
  assign m_top  = m_data[2*mf3_pkg::PIX_BITS-1:mf3_pkg::PIX_BITS];
  assign m_mid  = m_data[mf3_pkg::PIX_BITS-1:0];

  always_comb begin
    m_v_nxt = m_v_r;
    if (acc_pix) begin
      m_v_nxt = 1'b1;
    end else if (m_move) begin
      m_v_nxt = 1'b0;
    end
    s1_v_nxt = s1_v_r;
    if (m_move && m_res_r) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_move) begin
      s2_v_nxt = 1'b1;
    end else if (s2_move) begin
      s2_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s2_move) begin
      out_v_nxt = 1'b1;
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= mf3_pkg::WIDTH_RESET;
      cfg_height_r <= mf3_pkg::HEIGHT_RESET;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      m_v_r        <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      win_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mf3_pkg::REG_FRAME_WIDTH:  cfg_width_r  <= cfg_data[mf3_pkg::WID_BITS-1:0];
          mf3_pkg::REG_FRAME_HEIGHT: cfg_height_r <= cfg_data[mf3_pkg::ROW_BITS-1:0];
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      m_v_r     <= m_v_nxt;
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      out_v_r   <= out_v_nxt;
      if (m_move) begin
        // shift left, newest column on the right
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= m_top;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= m_mid;
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= m_pix_r;
      end
    end
  end

  // line-store RAM
  always_ff @(posedge clk) begin
    if (acc_pix) begin
      mem_rd_r <= lmem[in_col_r];
    end
    if (m_move) begin
      lmem[m_col_r] <= {m_mid, m_pix_r};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc_pix) begin
      m_col_r      <= in_col_r;
      m_pix_r      <= acc_p;
      m_res_r      <= has_res;
      m_int_r      <= res_int;
      m_last_r     <= res_last;
      // same column written back at this edge: RAM read is stale
      m_fwd_r      <= m_move && (m_col_r == in_col_r);
      m_fwd_data_r <= {m_mid, m_pix_r};
    end
    if (m_move && m_res_r) begin
      s1_int_r  <= m_int_r;
      s1_last_r <= m_last_r;
    end
    if (s1_move) begin
      s2_vals_r   <= med_front(win_r);
      s2_center_r <= win_r[4];
      s2_int_r    <= s1_int_r;
      s2_last_r   <= s1_last_r;
    end
    if (s2_move) begin
      out_word_r.pixel_out     <= s2_int_r ? med_back(s2_vals_r) : s2_center_r;
      out_word_r.last_of_frame <= s2_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/core/mf3_checker.sv
// mf3_checker: port-level checks for median_filter_3x3, bound into every median_filter_3x3 instance.
// Depends on mf3_pkg for the word types.
module mf3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mf3_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("out word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // input side only backs up behind a held output word
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || !out_stall |-> !in_stall)
    else $error("in_stall without output backpressure");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);

>>> verif/tb_median_filter_3x3.sv
// tb_median_filter_3x3: self-checking testbench for the streaming 3x3 median filter.
// Needs mf3_pkg and median_filter_3x3; a scoreboard class predicts every output word,
// and plain tasks drive the pixel stream and the register port.
module tb_median_filter_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 460;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;

  localparam mf3_pkg::pix_t DEMO_FRAME [9] = '{8'd255, 8'd0, 8'd128,
                                               8'd7, 8'd255, 8'd0,
                                               8'd0, 8'd255, 8'd200};

  class median_scoreboard;
    logic [mf3_pkg::WID_BITS-1:0] width_reg;
    logic [mf3_pkg::ROW_BITS-1:0] height_reg;
    mf3_pkg::pix_t      upper [mf3_pkg::MAX_WIDTH];
    mf3_pkg::pix_t      middle [mf3_pkg::MAX_WIDTH];
    mf3_pkg::pix_t      win [3][3];
    int unsigned        in_col, in_row, out_col, out_row;
    mf3_pkg::out_word_t expected_words [$];
    int unsigned        mismatches;

    function new();
      width_reg  = mf3_pkg::WIDTH_RESET;
      height_reg = mf3_pkg::HEIGHT_RESET;
      foreach (upper[i]) begin
        upper[i]  = '0;
        middle[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic [mf3_pkg::IDX_BITS-1:0] idx,
                            logic [mf3_pkg::CFG_BITS-1:0] data);
      case (idx)
        mf3_pkg::REG_FRAME_WIDTH:  width_reg = data[mf3_pkg::WID_BITS-1:0];
        mf3_pkg::REG_FRAME_HEIGHT: height_reg = data[mf3_pkg::ROW_BITS-1:0];
        default: ;
      endcase
      restart();
    endfunction

    // rank selection: the value with at most four smaller and at least five not larger
    function mf3_pkg::pix_t median9();
      mf3_pkg::pix_t v [9];
      int unsigned   below, same;
      mf3_pkg::pix_t res;
      res = '0;
      foreach (win[r, c]) v[r * 3 + c] = win[r][c];
      for (int i = 0; i < 9; i++) begin
        below = 0;
        same  = 0;
        for (int j = 0; j < 9; j++) begin
          if (v[j] < v[i]) below++;
          else if (v[j] == v[i]) same++;
        end
        if (below <= 4 && below + same >= 5) res = v[i];
      end
      return res;
    endfunction

    function void note_word(mf3_pkg::in_word_t w);
      int unsigned   wd, ht, n;
      bit            frame_full, last;
      mf3_pkg::pix_t p, top, mid, val;
      wd = (width_reg == 0) ? 1 :
           (width_reg > mf3_pkg::MAX_WIDTH) ? mf3_pkg::MAX_WIDTH : width_reg;
      ht = (height_reg == 0) ? 1 : height_reg;
      frame_full = (in_row >= ht);
      if (!frame_full && w.kind == KIND_DRAIN) return;
      // once the frame is in, any word just pushes zeros through
      p = frame_full ? '0 : w.pixel_in;
      n = in_row * wd + in_col;
      top = upper[in_col];
      mid = middle[in_col];
      upper[in_col]  = mid;
      middle[in_col] = p;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = p;
      in_col++;
      if (in_col >= wd) begin
        in_col = 0;
        in_row++;
      end
      if (n < wd + 1) return;
      if (out_row >= 1 && out_row + 1 < ht && out_col >= 1 && out_col + 1 < wd)
        val = median9();
      else
        val = win[1][1];
      last = (out_row + 1 >= ht) && (out_col + 1 >= wd);
      expected_words.push_back(mf3_pkg::out_word_t'{pixel_out: val, last_of_frame: last});
      if (last) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= wd) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_word(mf3_pkg::out_word_t got);
      mf3_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word pixel_out %0d last_of_frame %0b",
                   $realtime, got.pixel_out, got.last_of_frame);
        return;
      end
      want = expected_words.pop_front();
      if (got.pixel_out !== want.pixel_out || got.last_of_frame !== want.last_of_frame) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch pixel_out exp %0d got %0d, last_of_frame exp %0b got %0b",
                   $realtime, want.pixel_out, got.pixel_out,
                   want.last_of_frame, got.last_of_frame);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  mf3_pkg::in_word_t            in_word = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  mf3_pkg::out_word_t           out_word;
  logic                         cfg_we = 1'b0;
  logic [mf3_pkg::IDX_BITS-1:0] cfg_index = '0;
  logic [mf3_pkg::CFG_BITS-1:0] cfg_data = '0;

  int unsigned       in_idle_pct = 19;
  int unsigned       out_idle_pct = 56;
  int unsigned       quiet_cycles = 0;
  median_scoreboard  sb;

  median_filter_3x3 u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // all handshakes sampled on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (out_valid && !out_stall) sb.check_word(out_word);
    end
    if (cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic mf3_pkg::pix_t rand_pix();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    if (r < 35) return mf3_pkg::pix_t'($urandom_range(103, 100));  // lots of ties
    return mf3_pkg::pix_t'($urandom);
  endfunction

  function automatic int unsigned eff_w(logic [mf3_pkg::CFG_BITS-1:0] d);
    int unsigned v;
    v = d[mf3_pkg::WID_BITS-1:0];
    if (v == 0) return 1;
    if (v > mf3_pkg::MAX_WIDTH) return mf3_pkg::MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned eff_h(logic [mf3_pkg::CFG_BITS-1:0] d);
    return (d == 0) ? 1 : d;
  endfunction

  function automatic logic [mf3_pkg::CFG_BITS-1:0] pick_width();
    int unsigned r, v;
    r = $urandom_range(99);
    if (r < 5) v = 0;
    else if (r < 10) v = 1;
    else if (r < 75) v = $urandom_range(8, 2);
    else if (r < 92) v = $urandom_range(24, 9);
    else v = $urandom_range(40, 25);
    // top bit is outside the width register
    return {1'($urandom_range(1)), mf3_pkg::WID_BITS'(v)};
  endfunction

  function automatic logic [mf3_pkg::CFG_BITS-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return mf3_pkg::CFG_BITS'(1);
    if (r < 80) return mf3_pkg::CFG_BITS'($urandom_range(6, 2));
    return mf3_pkg::CFG_BITS'($urandom_range(12, 7));
  endfunction

  task automatic push_word(input logic kind, input mf3_pkg::pix_t pix);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= mf3_pkg::in_word_t'{kind: kind, pixel_in: pix};
    do @(posedge clk); while (in_stall);
  endtask

  // only with the pipe empty: wait out the last word, then let it settle
  task automatic write_regs(input logic [mf3_pkg::CFG_BITS-1:0] wv,
                            input logic [mf3_pkg::CFG_BITS-1:0] hv);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mf3_pkg::REG_FRAME_WIDTH;
    cfg_data  <= wv;
    @(posedge clk);
    cfg_index <= mf3_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= hv;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned wd, input int unsigned ht);
    for (int unsigned i = 0; i < wd * ht; i++) begin
      if ($urandom_range(19) == 0) push_word(KIND_DRAIN, rand_pix());  // dropped mid-frame
      push_word(KIND_PIXEL, rand_pix());
    end
    // tail flush; a pixel word here counts as a drain word
    for (int unsigned i = 0; i <= wd; i++)
      push_word(($urandom_range(4) == 0) ? KIND_PIXEL : KIND_DRAIN, rand_pix());
    if ($urandom_range(3) == 0) push_word(KIND_DRAIN, rand_pix());
  endtask

  initial begin
    int unsigned                  done_items;
    int unsigned                  wd, ht, k;
    bit                           first;
    logic [mf3_pkg::CFG_BITS-1:0] wv, hv;
    sb = new();
    done_items = 0;
    first = 1;
    wv = '0;
    hv = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 640 wide: first word out only with the 642nd word in
    repeat (700) push_word(KIND_PIXEL, rand_pix());

    write_regs(mf3_pkg::CFG_BITS'(3), mf3_pkg::CFG_BITS'(3));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_word(KIND_DRAIN, 8'hFF);
      push_word(KIND_PIXEL, DEMO_FRAME[i]);
    end
    push_word(KIND_DRAIN, 8'h00);
    push_word(KIND_PIXEL, 8'd99);
    push_word(KIND_DRAIN, 8'hFF);
    push_word(KIND_DRAIN, 8'h55);
    push_word(KIND_DRAIN, 8'hAA);  // after the last word: ignored

    // below 3 wide/high everything passes straight through
    write_regs(mf3_pkg::CFG_BITS'(2), mf3_pkg::CFG_BITS'(2));
    for (int i = 0; i < 4; i++) push_word(KIND_PIXEL, 8'(8'hF0 + i));
    for (int i = 0; i < 3; i++) push_word(KIND_DRAIN, 8'h0F);

    // width 0 behaves as 1; tallest frame, cut short by the next write
    write_regs('0, 12'hFFF);
    repeat (60) push_word(KIND_PIXEL, rand_pix());

    while (done_items < RANDOM_ITEMS) begin
      if (done_items < RANDOM_ITEMS / 3) begin
        in_idle_pct  = 19;
        out_idle_pct = 56;
      end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct  = 56;
        out_idle_pct = 19;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (first || $urandom_range(2) == 0) begin
        wv = pick_width();
        hv = pick_height();
        write_regs(wv, hv);
        first = 0;
      end
      wd = eff_w(wv);
      ht = eff_h(hv);
      if ($urandom_range(99) < 15) begin
        k = $urandom_range(wd * ht + wd, 1);
        repeat (k)
          push_word(($urandom_range(3) == 0) ? KIND_DRAIN : KIND_PIXEL, rand_pix());
        write_regs(wv, hv);  // abandon the partial frame
        done_items += k;
      end else begin
        send_frame(wd, ht);
        done_items += wd * ht + wd + 1;
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mf3_pkg.sv
rtl/core/median_filter_3x3.sv
rtl/core/mf3_checker.sv
verif/tb_median_filter_3x3.sv
